@@ src/frs_pkg.sv @@
// ----------------------------------------------------------------------------
// frs_pkg: shared types and constants of the fitness replacement selector
// Transaction structs, field widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

  localparam int SLOT_W    = 6;
  localparam int FIT_W     = 32;
  localparam int COUNT_W   = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int SLOT_LIMIT = 64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHILD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POP_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHILD_COUNT = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] slot;
    logic [FIT_W-1:0]  fitness;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] pop_index;
    logic [SLOT_W-1:0] child_index;
    logic [FIT_W-1:0]  new_fitness;
    logic              replaced;
    logic              last;
  } result_t;

  // Control of the shared max-search unit
  typedef struct packed {
    logic clear;
    logic valid;
    logic elig;
  } scan_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CSCAN,
    ST_PSCAN
  } state_t;

  // Zero acts as one; saturate at the table limit
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                     input logic [COUNT_W-1:0] lim);
    logic [COUNT_W-1:0] r;
    r = v;
    if (r == '0) r = COUNT_W'(1);
    if (r > lim) r = lim;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/frs_mem.sv @@
// ----------------------------------------------------------------------------
// frs_mem: single write, single read fitness memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [frs_pkg::FIT_W-1:0] wdata,
  input  wire logic [AW-1:0]            raddr,
  output      logic [frs_pkg::FIT_W-1:0] rdata
);

  logic [frs_pkg::FIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/frs_max_unit.sv @@
// ----------------------------------------------------------------------------
// frs_max_unit: shared running-maximum search
// Keeps the highest eligible value seen and its index, first index on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_max_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire frs_pkg::scan_ctl_t        ctl,
  input  wire logic [frs_pkg::SLOT_W-1:0] idx,
  input  wire logic [frs_pkg::FIT_W-1:0]  value,
  output      logic [frs_pkg::SLOT_W-1:0] best_idx,
  output      logic [frs_pkg::FIT_W-1:0]  best_val
);

  logic have;
  logic take;

  // strict compare keeps the lower index on ties
  assign take = ctl.valid && ctl.elig && (!have || (value > best_val));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctl.clear) begin
      have <= 1'b0;
    end else if (take) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx <= idx;
      best_val <= value;
    end
  end

endmodule

`default_nettype wire

@@ src/fitness_replacement_selector.sv @@
// ----------------------------------------------------------------------------
// fitness_replacement_selector: elitist replacement for a genetic algorithm
// Holds population and child fitness tables and selects replacements.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A load item writes
//   one population slot; a child item writes one child entry and counts it.
//   Neither gives a record unless the child completes the generation: then
//   a selection run starts and busy stays high until done. Per child in the
//   run the sequencer walks the child memory once to find the next child in
//   descending fitness order, then walks the population memory to find the
//   worst slot, all through one shared compare unit fed from the registered
//   memory read port.
//   Each record appears on result for one cycle with done high; the receiver
//   cannot stall. The final record carries last and busy falls with it.
//   Configuration writes through cfg_we/cfg_index/cfg_data take effect at
//   once; the user must make them while busy is low, the block does not enforce it.
//   Reset clears the child counter and sequencer and sets both counts to 64;
//   table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module fitness_replacement_selector #(
  parameter int POP_MAX   = 64,
  parameter int CHILD_MAX = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire frs_pkg::item_t                item,
  output      logic                          done,
  output      frs_pkg::result_t              result,
  input  wire logic                          cfg_we,
  input  wire logic [frs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frs_pkg::CFG_W-1:0]     cfg_data
);

  localparam int POP_DEPTH   = (POP_MAX < frs_pkg::SLOT_LIMIT) ? POP_MAX : frs_pkg::SLOT_LIMIT;
  localparam int CHILD_DEPTH = (CHILD_MAX < frs_pkg::SLOT_LIMIT) ? CHILD_MAX
                                                                 : frs_pkg::SLOT_LIMIT;
  localparam int AWP = (POP_DEPTH > 1) ? $clog2(POP_DEPTH) : 1;
  localparam int AWC = (CHILD_DEPTH > 1) ? $clog2(CHILD_DEPTH) : 1;
  localparam logic [frs_pkg::COUNT_W-1:0] POP_LIM   = frs_pkg::COUNT_W'(POP_DEPTH);
  localparam logic [frs_pkg::COUNT_W-1:0] CHILD_LIM = frs_pkg::COUNT_W'(CHILD_DEPTH);

  frs_pkg::state_t state, state_next;

  logic [frs_pkg::COUNT_W-1:0] pop_size;
  logic [frs_pkg::COUNT_W-1:0] child_count;
  logic [frs_pkg::COUNT_W-1:0] received;
  logic [frs_pkg::COUNT_W-1:0] received_inc;
  logic [frs_pkg::COUNT_W-1:0] n_pop;
  logic [frs_pkg::COUNT_W-1:0] n_child;
  logic [frs_pkg::COUNT_W-1:0] scan_n;
  logic [frs_pkg::COUNT_W-1:0] cnt;
  logic [frs_pkg::COUNT_W-1:0] round;
  logic                        rd_valid;
  logic [frs_pkg::SLOT_W-1:0]  rd_idx;
  logic [CHILD_DEPTH-1:0]      used;

  logic [frs_pkg::SLOT_W-1:0]  c_idx;
  logic [frs_pkg::FIT_W-1:0]   c_val;

  logic                        accept;
  logic                        run_start;
  logic                        issue;
  logic                        scan_done;
  logic                        last_round;
  logic                        rep;

  logic                        pop_we;
  logic [AWP-1:0]              pop_waddr;
  logic [frs_pkg::FIT_W-1:0]   pop_wdata;
  logic [frs_pkg::FIT_W-1:0]   pop_rdata;
  logic                        child_we;
  logic [frs_pkg::FIT_W-1:0]   child_rdata;

  frs_pkg::scan_ctl_t          ctl;
  logic [frs_pkg::FIT_W-1:0]   scan_val;
  logic [frs_pkg::SLOT_W-1:0]  best_idx;
  logic [frs_pkg::FIT_W-1:0]   best_val;

  assign n_pop        = frs_pkg::clamp_count(pop_size, POP_LIM);
  assign n_child      = frs_pkg::clamp_count(child_count, CHILD_LIM);
  assign received_inc = received + frs_pkg::COUNT_W'(1);
  assign accept       = start && (state == frs_pkg::ST_IDLE);
  assign run_start    = accept && (item.operation == frs_pkg::OP_CHILD)
                        && (received_inc >= n_child);
  assign scan_n       = (state == frs_pkg::ST_CSCAN) ? n_child : n_pop;
  assign last_round   = (round + frs_pkg::COUNT_W'(1)) == n_child;
  assign rep          = c_val < best_val;
  assign busy         = (state != frs_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      frs_pkg::ST_IDLE: begin
        if (run_start) state_next = frs_pkg::ST_CSCAN;
      end
      frs_pkg::ST_CSCAN: begin
        if (scan_done) state_next = frs_pkg::ST_PSCAN;
      end
      frs_pkg::ST_PSCAN: begin
        if (scan_done) state_next = last_round ? frs_pkg::ST_IDLE : frs_pkg::ST_CSCAN;
      end
      default: state_next = frs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    issue     = 1'b0;
    scan_done = 1'b0;
    case (state)
      frs_pkg::ST_CSCAN, frs_pkg::ST_PSCAN: begin
        issue     = cnt < scan_n;
        scan_done = (cnt == scan_n) && !rd_valid;
      end
      default: begin
        issue     = 1'b0;
        scan_done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pop_size    <= frs_pkg::COUNT_W'(frs_pkg::SLOT_LIMIT);
      child_count <= frs_pkg::COUNT_W'(frs_pkg::SLOT_LIMIT);
    end else if (cfg_we) begin
      case (cfg_index)
        frs_pkg::REG_POP_SIZE:    pop_size    <= cfg_data;
        frs_pkg::REG_CHILD_COUNT: child_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Generation counter
  always_ff @(posedge clk) begin
    if (rst) begin
      received <= '0;
    end else if (accept && (item.operation == frs_pkg::OP_CHILD)) begin
      received <= run_start ? '0 : received_inc;
    end
  end

  // Walk counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rd_valid <= 1'b0;
      round    <= '0;
      used     <= '0;
      done     <= 1'b0;
    end else begin
      rd_valid <= issue;
      done     <= 1'b0;
      if (scan_done) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + frs_pkg::COUNT_W'(1);
      end
      if (run_start) begin
        used  <= '0;
        round <= '0;
      end else if (scan_done && (state == frs_pkg::ST_PSCAN)) begin
        used[c_idx[AWC-1:0]] <= 1'b1;
        round <= round + frs_pkg::COUNT_W'(1);
        done  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt[frs_pkg::SLOT_W-1:0];
    if (scan_done && (state == frs_pkg::ST_CSCAN)) begin
      c_idx <= best_idx;
      c_val <= best_val;
    end
    if (scan_done && (state == frs_pkg::ST_PSCAN)) begin
      result.pop_index   <= best_idx;
      result.child_index <= c_idx;
      result.new_fitness <= rep ? c_val : best_val;
      result.replaced    <= rep;
      result.last        <= last_round;
    end
  end

  // Memory write selection: loads while idle, replacements at the end of a walk
  always_comb begin
    pop_we    = 1'b0;
    pop_waddr = item.slot[AWP-1:0];
    pop_wdata = item.fitness;
    if (scan_done && (state == frs_pkg::ST_PSCAN)) begin
      pop_we    = rep;
      pop_waddr = best_idx[AWP-1:0];
      pop_wdata = c_val;
    end else if (accept && (item.operation == frs_pkg::OP_LOAD)) begin
      pop_we = ({1'b0, item.slot} < POP_LIM);
    end
  end

  assign child_we = accept && (item.operation == frs_pkg::OP_CHILD)
                    && ({1'b0, item.slot} < CHILD_LIM);

  frs_mem #(.DEPTH(POP_DEPTH), .AW(AWP)) u_pop_mem (
    .clk   (clk),
    .we    (pop_we),
    .waddr (pop_waddr),
    .wdata (pop_wdata),
    .raddr (cnt[AWP-1:0]),
    .rdata (pop_rdata)
  );

  frs_mem #(.DEPTH(CHILD_DEPTH), .AW(AWC)) u_child_mem (
    .clk   (clk),
    .we    (child_we),
    .waddr (item.slot[AWC-1:0]),
    .wdata (item.fitness),
    .raddr (cnt[AWC-1:0]),
    .rdata (child_rdata)
  );

  // Shared compare unit: skip children already placed during the child walk
  always_comb begin
    ctl.clear = scan_done || run_start;
    ctl.valid = rd_valid;
    ctl.elig  = 1'b1;
    scan_val  = pop_rdata;
    if (state == frs_pkg::ST_CSCAN) begin
      ctl.elig = !used[rd_idx[AWC-1:0]];
      scan_val = child_rdata;
    end
  end

  frs_max_unit u_max (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .idx      (rd_idx),
    .value    (scan_val),
    .best_idx (best_idx),
    .best_val (best_val)
  );

endmodule

`default_nettype wire

@@ src/frs_checker.sv @@
// ----------------------------------------------------------------------------
// frs_checker: port-level checks of the fitness replacement selector
// Watches busy, done and the last flag over time.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             busy,
  input wire logic             done,
  input wire frs_pkg::result_t result
);

  // a record only comes out of a run in progress
  a_idle_no_record: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !done)
    else $error("record delivered without a selection run");

  // records are separated by walks
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two records in consecutive cycles");

  a_mid_record_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last) |-> busy)
    else $error("run ended before its final record");

  a_end_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done && result.last))
    else $error("run ended without a last record");

endmodule

bind fitness_replacement_selector frs_checker u_frs_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fitness_replacement_selector
// Loads population and child fitness values, predicts every replacement
// record of each selection run and checks the records as the block emits them,
// across several population and generation sizes and varying start gaps.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int SETTLE      = 4;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          start     = 1'b0;
  logic                          busy;
  frs_pkg::item_t                item      = '0;
  logic                          done;
  frs_pkg::result_t              result;
  logic                          cfg_we    = 1'b0;
  logic [frs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [frs_pkg::CFG_W-1:0]     cfg_data  = '0;

  fitness_replacement_selector uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted block state
  logic [frs_pkg::FIT_W-1:0]   pop_fit [frs_pkg::SLOT_LIMIT];
  logic [frs_pkg::FIT_W-1:0]   kid_fit [frs_pkg::SLOT_LIMIT];
  logic [frs_pkg::COUNT_W-1:0] kids_seen       = '0;
  logic [frs_pkg::COUNT_W-1:0] pop_size_reg    = frs_pkg::COUNT_W'(64);
  logic [frs_pkg::COUNT_W-1:0] child_count_reg = frs_pkg::COUNT_W'(64);
  frs_pkg::result_t            pending_records [$];

  // Stimulus-side view: which entries hold a value, generation progress
  bit  pop_loaded [frs_pkg::SLOT_LIMIT];
  bit  kid_loaded [frs_pkg::SLOT_LIMIT];
  int  gen_np   = 64;
  int  gen_nc   = 64;
  int  gen_kids = 0;

  frs_pkg::item_t   item_backlog [$];
  int               send_idle_pct = 34;
  int               mismatches    = 0;
  int               cycles        = 0;
  frs_pkg::result_t want;

  function automatic int active_count(logic [frs_pkg::COUNT_W-1:0] v);
    if (v == '0) return 1;
    if (v > frs_pkg::SLOT_LIMIT) return frs_pkg::SLOT_LIMIT;
    return int'(v);
  endfunction

  // Apply one transaction; a completing child yields one record per child
  function automatic void select_replacements(frs_pkg::item_t it);
    int               nc;
    int               np;
    int               worst;
    int               pick;
    bit               taken [frs_pkg::SLOT_LIMIT];
    frs_pkg::result_t rec;
    if (it.operation == frs_pkg::OP_LOAD) begin
      pop_fit[it.slot] = it.fitness;
      return;
    end
    kid_fit[it.slot] = it.fitness;
    nc = active_count(child_count_reg);
    kids_seen = kids_seen + frs_pkg::COUNT_W'(1);
    if (int'(kids_seen) < nc) return;
    kids_seen = '0;
    np = active_count(pop_size_reg);
    foreach (taken[i]) taken[i] = 1'b0;
    for (int k = 0; k < nc; k++) begin
      // highest remaining child fitness, lowest index on ties
      pick = -1;
      for (int c = 0; c < nc; c++) begin
        if (!taken[c] && (pick < 0 || kid_fit[c] > kid_fit[pick])) pick = c;
      end
      taken[pick] = 1'b1;
      worst = 0;
      for (int p = 1; p < np; p++) begin
        if (pop_fit[p] > pop_fit[worst]) worst = p;
      end
      rec.replaced = kid_fit[pick] < pop_fit[worst];
      if (rec.replaced) pop_fit[worst] = kid_fit[pick];
      rec.pop_index   = frs_pkg::SLOT_W'(worst);
      rec.child_index = frs_pkg::SLOT_W'(pick);
      rec.new_fitness = pop_fit[worst];
      rec.last        = (k == nc - 1);
      pending_records.push_back(rec);
    end
  endfunction

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) select_replacements(item);
      if (!start || !busy) begin
        if (item_backlog.size() > 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          item  <= item_backlog.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record: %p", result);
      end else begin
        want = pending_records.pop_front();
        if (result.pop_index !== want.pop_index || result.child_index !== want.child_index ||
            result.new_fitness !== want.new_fitness || result.replaced !== want.replaced ||
            result.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch (expected/actual): pop_index %0d/%0d child_index %0d/%0d",
                     want.pop_index, result.pop_index, want.child_index, result.child_index,
                     " new_fitness %h/%h replaced %b/%b last %b/%b",
                     want.new_fitness, result.new_fitness, want.replaced, result.replaced,
                     want.last, result.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [frs_pkg::FIT_W-1:0] pick_fitness();
    case ($urandom_range(9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return frs_pkg::FIT_W'($urandom_range(15));
      default:    return frs_pkg::FIT_W'($urandom);
    endcase
  endfunction

  function automatic void shuffle_slots(ref int s [$]);
    int j;
    int t;
    for (int i = s.size() - 1; i > 0; i--) begin
      j    = $urandom_range(i);
      t    = s[i];
      s[i] = s[j];
      s[j] = t;
    end
  endfunction

  function automatic void queue_item(logic op, int slot, logic [frs_pkg::FIT_W-1:0] fit);
    int             remaining;
    int             missing;
    int             first_gap;
    frs_pkg::item_t it;
    if (op == frs_pkg::OP_CHILD) begin
      remaining = (gen_kids < gen_nc) ? gen_nc - gen_kids : 1;
      missing   = 0;
      first_gap = 0;
      for (int c = gen_nc - 1; c >= 0; c--) begin
        if (!kid_loaded[c]) begin
          missing++;
          first_gap = c;
        end
      end
      // steer onto an empty child entry while the rest of the generation cannot fill them all
      if (missing >= remaining && (slot >= gen_nc || kid_loaded[slot])) slot = first_gap;
      kid_loaded[slot] = 1'b1;
      gen_kids = (gen_kids + 1 >= gen_nc) ? 0 : gen_kids + 1;
    end else begin
      pop_loaded[slot] = 1'b1;
    end
    it.operation = op;
    it.slot      = frs_pkg::SLOT_W'(slot);
    it.fitness   = fit;
    item_backlog.push_back(it);
  endfunction

  task automatic write_reg(logic [frs_pkg::CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= frs_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == frs_pkg::REG_POP_SIZE) begin
      pop_size_reg = frs_pkg::COUNT_W'(val);
      gen_np       = active_count(frs_pkg::COUNT_W'(val));
    end else begin
      child_count_reg = frs_pkg::COUNT_W'(val);
      gen_nc          = active_count(frs_pkg::COUNT_W'(val));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (item_backlog.size() != 0 || start || busy || pending_records.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int pop_val, int kid_val, int gens, int idle_pct);
    int lineup [$];
    bit tidy;
    write_reg(frs_pkg::REG_POP_SIZE, pop_val);
    write_reg(frs_pkg::REG_CHILD_COUNT, kid_val);
    send_idle_pct = idle_pct;
    @(negedge clk);
    // load every population slot in use before any run can read it
    lineup = {};
    for (int p = 0; p < gen_np; p++) begin
      if (!pop_loaded[p]) lineup.push_back(p);
    end
    shuffle_slots(lineup);
    foreach (lineup[i]) queue_item(frs_pkg::OP_LOAD, lineup[i], pick_fitness());
    repeat (gens) begin
      lineup = {};
      tidy   = int'($urandom_range(99)) < 85;
      for (int c = 0; c < gen_nc; c++) lineup.push_back(tidy ? c : int'($urandom_range(63)));
      if (tidy) shuffle_slots(lineup);
      foreach (lineup[i]) begin
        if ($urandom_range(99) < 20)
          queue_item(frs_pkg::OP_LOAD, $urandom_range(63), pick_fitness());
        queue_item(frs_pkg::OP_CHILD, lineup[i], pick_fitness());
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Single slot, ties at the top of the range, then strict replacements
    write_reg(frs_pkg::REG_POP_SIZE, 0);
    write_reg(frs_pkg::REG_CHILD_COUNT, 2);
    @(negedge clk);
    queue_item(frs_pkg::OP_LOAD, 0, '1);
    queue_item(frs_pkg::OP_LOAD, 63, '0);
    queue_item(frs_pkg::OP_CHILD, 1, '1);
    queue_item(frs_pkg::OP_CHILD, 0, '1);
    queue_item(frs_pkg::OP_CHILD, 0, frs_pkg::FIT_W'(5));
    queue_item(frs_pkg::OP_CHILD, 1, '0);
    wait_idle();

    // Tied worst slots, tied children, equal fitness kept; leave a partial generation
    write_reg(frs_pkg::REG_POP_SIZE, 4);
    write_reg(frs_pkg::REG_CHILD_COUNT, 3);
    @(negedge clk);
    queue_item(frs_pkg::OP_LOAD, 0, frs_pkg::FIT_W'(2));
    queue_item(frs_pkg::OP_LOAD, 1, frs_pkg::FIT_W'(9));
    queue_item(frs_pkg::OP_LOAD, 2, frs_pkg::FIT_W'(9));
    queue_item(frs_pkg::OP_LOAD, 3, frs_pkg::FIT_W'(1));
    queue_item(frs_pkg::OP_CHILD, 2, frs_pkg::FIT_W'(9));
    queue_item(frs_pkg::OP_CHILD, 0, frs_pkg::FIT_W'(4));
    queue_item(frs_pkg::OP_CHILD, 1, frs_pkg::FIT_W'(4));
    queue_item(frs_pkg::OP_CHILD, 63, '0);
    wait_idle();

    // Lower the count below the children already held: next child triggers the run
    write_reg(frs_pkg::REG_CHILD_COUNT, 0);
    @(negedge clk);
    queue_item(frs_pkg::OP_CHILD, 0, frs_pkg::FIT_W'(1));
    wait_idle();

    random_phase(127, 100, 1, 34);
    random_phase(5, 3, 9, 34);
    random_phase(1, 1, 17, 52);
    random_phase(64, 7, 2, 52);
    random_phase(2, 16, 2, 0);
    random_phase(33, 9, 3, 0);

    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ fitness_replacement_selector.f @@
src/frs_pkg.sv
src/frs_mem.sv
src/frs_max_unit.sv
src/fitness_replacement_selector.sv
src/frs_checker.sv
verif/testbench.sv
